@@ rtl/fadd_pkg.sv @@
// ----------------------------------------------------------------------------
// fadd_pkg: shared types and constants for the single-precision adder.
// Holds the operand class codes and the special result words.
// ----------------------------------------------------------------------------
`default_nettype none

package fadd_pkg;

  // Operand classes.
  typedef enum logic [2:0] {
    K_ZERO,
    K_INF,
    K_NAN,
    K_NORMAL,
    K_DENORM
  } kind_t;

  localparam logic [31:0] QUIET_MASK = 32'h7FC0_0000;
  localparam logic [31:0] INF_CLASH  = 32'hFFC0_0000;
  localparam logic [9:0]  EXP_MAX    = 10'd255;

  // Class of one operand from its exponent and fraction fields.
  function automatic kind_t classify(input logic [7:0] e, input logic [22:0] m);
    kind_t k;
    if (e == 8'd0) begin
      k = (m == 23'd0) ? K_ZERO : K_DENORM;
    end else if (e == 8'hFF) begin
      k = (m == 23'd0) ? K_INF : K_NAN;
    end else begin
      k = K_NORMAL;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

@@ rtl/float32_adder_top.sv @@
// An accepted transaction moves through the stage 2, 3 and 4 registers and then the output register.
// One transaction per cycle while the output is not stalled; the four pipeline stages advance together.
// A stall at the output holds every stage in place.
// Reset clears the stage valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// float32_adder_top: pipelined single-precision adder.
// Classify and align, add, normalize, then round and pack.
// ----------------------------------------------------------------------------
`default_nettype none

module float32_adder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_operand_a,
  input  wire logic [31:0] in_operand_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_sum_word
);

  // The whole pipe moves when the last stage is empty or being drained.
  logic adv;
  logic v1_r, v2_r, v3_r, v4_r;
  assign adv      = !v4_r || out_ready;
  assign in_ready = adv;

  // ---------------- Stage 1: classify, order operands, align ----------------
  logic [31:0] a, b;
  logic        sa, sb;
  logic [7:0]  ea8, eb8;
  logic [22:0] fa, fb;
  fadd_pkg::kind_t ka, kb;
  logic        s1_special;
  logic [31:0] s1_word;
  logic [9:0]  ea, eb;
  logic [23:0] ma, mb;
  logic        s1_sign, s1_zero, s1_sub;
  logic [9:0]  s1_ex, d;
  logic [25:0] big, sml, small_sh;
  logic        s1_sticky;

  assign a   = in_operand_a;
  assign b   = in_operand_b;
  assign sa  = a[31];
  assign sb  = b[31];
  assign ea8 = a[30:23];
  assign eb8 = b[30:23];
  assign fa  = a[22:0];
  assign fb  = b[22:0];
  assign ka  = fadd_pkg::classify(ea8, fa);
  assign kb  = fadd_pkg::classify(eb8, fb);

  always_comb begin
    s1_special = 1'b1;
    s1_word    = 32'd0;
    if (ka == fadd_pkg::K_NAN || kb == fadd_pkg::K_NAN) begin
      s1_word = (ka == fadd_pkg::K_NAN && kb != fadd_pkg::K_NAN) ?
                (a | fadd_pkg::QUIET_MASK) : (b | fadd_pkg::QUIET_MASK);
    end else if (ka == fadd_pkg::K_INF || kb == fadd_pkg::K_INF) begin
      if (ka != fadd_pkg::K_INF)      s1_word = b;
      else if (kb != fadd_pkg::K_INF) s1_word = a;
      else s1_word = (sa == sb) ? a : fadd_pkg::INF_CLASH;
    end else if (ka == fadd_pkg::K_ZERO || kb == fadd_pkg::K_ZERO) begin
      if (ka != fadd_pkg::K_ZERO)      s1_word = a;
      else if (kb != fadd_pkg::K_ZERO) s1_word = b;
      else s1_word = {sa & sb, 31'd0};
    end else begin
      s1_special = 1'b0;
    end
  end

  // Denormals take exponent 1 and no hidden bit.
  assign ea = (ka == fadd_pkg::K_DENORM) ? 10'd1 : {2'b00, ea8};
  assign eb = (kb == fadd_pkg::K_DENORM) ? 10'd1 : {2'b00, eb8};
  assign ma = {ka != fadd_pkg::K_DENORM, fa};
  assign mb = {kb != fadd_pkg::K_DENORM, fb};
  assign s1_sub = sa ^ sb;

  always_comb begin
    s1_zero = 1'b0;
    s1_sign = sa;
    s1_ex   = ea;
    d       = 10'd0;
    big     = {ma, 2'b00};
    sml     = {mb, 2'b00};
    if (ea > eb) begin
      d = ea - eb;
    end else if (ea < eb) begin
      s1_sign = sb;
      s1_ex   = eb;
      d       = eb - ea;
      big     = {mb, 2'b00};
      sml     = {ma, 2'b00};
    end else if (ma < mb) begin
      s1_sign = sb;
      big     = {mb, 2'b00};
      sml     = {ma, 2'b00};
    end else if (ma == mb && s1_sub) begin
      s1_zero = 1'b1;
    end
  end

  // Alignment shift with sticky collection.
  always_comb begin
    if (d >= 10'd26) begin
      small_sh  = 26'd0;
      s1_sticky = (sml != 26'd0);
    end else begin
      small_sh  = sml >> d[4:0];
      s1_sticky = ((sml & ((26'd1 << d[4:0]) - 26'd1)) != 26'd0);
    end
  end

  logic        s2_special_r, s2_zero_r, s2_sign_r, s2_sub_r, s2_sticky_r, s2_bden_r;
  logic [31:0] s2_word_r;
  logic [9:0]  s2_ex_r;
  logic [25:0] s2_big_r, s2_small_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_special_r <= s1_special;
      s2_word_r    <= s1_word;
      s2_zero_r    <= s1_zero;
      s2_sign_r    <= s1_sign;
      s2_sub_r     <= s1_sub;
      s2_sticky_r  <= s1_sticky;
      s2_bden_r    <= (ka == fadd_pkg::K_DENORM) && (kb == fadd_pkg::K_DENORM);
      s2_ex_r      <= s1_ex;
      s2_big_r     <= big;
      s2_small_r   <= small_sh;
    end
  end

  // ---------------- Stage 2: add or subtract, count leading zeros ----------
  logic [25:0] s2_sum;
  logic [4:0]  s2_lz;
  assign s2_sum = s2_sub_r ? (s2_big_r - s2_small_r) : (s2_big_r + s2_small_r);

  // Shift needed to reach bit 25 (sum may be up to 26 bits, carry dropped).
  always_comb begin
    s2_lz = 5'd0;
    for (int i = 0; i <= 25; i++) begin
      if (s2_sum[i]) s2_lz = 5'(25 - i);
    end
  end

  logic        s3_special_r, s3_zero_r, s3_sign_r, s3_sub_r, s3_sticky_r, s3_bden_r;
  logic [31:0] s3_word_r;
  logic [9:0]  s3_ex_r;
  logic [26:0] s3_sum_r;
  logic [4:0]  s3_lz_r;

  // Carry of an addition is kept as bit 26 for the normalize step.
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_special_r <= s2_special_r;
      s3_word_r    <= s2_word_r;
      s3_zero_r    <= s2_zero_r;
      s3_sign_r    <= s2_sign_r;
      s3_sub_r     <= s2_sub_r;
      s3_sticky_r  <= s2_sticky_r;
      s3_bden_r    <= s2_bden_r;
      s3_ex_r      <= s2_ex_r;
      s3_sum_r     <= s2_sub_r ? {1'b0, s2_sum} :
                      ({1'b0, s2_big_r} + {1'b0, s2_small_r});
      s3_lz_r      <= s2_lz;
    end
  end

  // ---------------- Stage 3: normalize ----------------
  logic [26:0] n_sum;
  logic [9:0]  n_ex;
  logic        n_sticky, n_noround, n_zero;
  logic [4:0]  sh;

  always_comb begin
    n_sum     = s3_sum_r;
    n_ex      = s3_ex_r;
    n_sticky  = s3_sticky_r;
    n_noround = 1'b0;
    n_zero    = s3_zero_r || (s3_sum_r == 27'd0);
    sh        = s3_lz_r;
    if (s3_sum_r[26:25] == 2'b00 && !n_zero) begin
      if (s3_bden_r) begin
        // Both denormal: ex is 1 here; stop at exponent 0, truncate.
        n_ex      = 10'd0;
        n_noround = 1'b1;
      end else if ({5'd0, sh} > s3_ex_r) begin
        n_ex      = 10'd0;
        n_sum     = 27'd0;
        n_noround = 1'b1;
      end else begin
        n_sum = s3_sum_r << sh;
        n_ex  = s3_ex_r - {5'd0, sh};
      end
    end
    if (n_sum > 27'h3FF_FFFF) begin
      if (n_sum[0]) n_sticky = 1'b1;
      n_sum = n_sum >> 1;
      n_ex  = n_ex + 10'd1;
      if (n_ex >= fadd_pkg::EXP_MAX) begin
        n_ex      = fadd_pkg::EXP_MAX;
        n_sum     = 27'd0;
        n_noround = 1'b1;
      end
    end
  end

  logic        s4_special_r, s4_zero_r, s4_sign_r, s4_sub_r, s4_sticky_r, s4_noround_r;
  logic [31:0] s4_word_r;
  logic [9:0]  s4_ex_r;
  logic [25:0] s4_sum_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_special_r <= s3_special_r;
      s4_word_r    <= s3_word_r;
      s4_zero_r    <= n_zero;
      s4_sign_r    <= s3_sign_r;
      s4_sub_r     <= s3_sub_r;
      s4_sticky_r  <= n_sticky;
      s4_noround_r <= n_noround;
      s4_ex_r      <= n_ex;
      s4_sum_r     <= n_sum[25:0];
    end
  end

  // ---------------- Stage 4: round and pack ----------------
  logic [1:0]  f;
  logic [24:0] r_sig;
  logic [9:0]  r_ex;
  logic        up;
  logic [31:0] r_word;

  always_comb begin
    f     = s4_sum_r[1:0];
    r_sig = {1'b0, s4_sum_r[25:2]};
    r_ex  = s4_ex_r;
    up    = 1'b0;
    if (!s4_noround_r) begin
      if (f == 2'd3)      up = 1'b1;
      else if (f == 2'd2) up = s4_sticky_r ? !s4_sub_r : r_sig[0];
      if (up) r_sig = r_sig + 25'd1;
      if (r_sig[24]) begin
        r_sig = r_sig >> 1;
        r_ex  = r_ex + 10'd1;
        if (r_ex >= fadd_pkg::EXP_MAX) begin
          r_ex  = fadd_pkg::EXP_MAX;
          r_sig = 25'd0;
        end
      end
    end
    if (s4_special_r)   r_word = s4_word_r;
    else if (s4_zero_r) r_word = 32'd0;
    else                r_word = {s4_sign_r, r_ex[7:0], r_sig[22:0]};
  end

  logic [31:0] out_r;
  always_ff @(posedge clk) begin
    if (adv) out_r <= r_word;
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign out_valid    = v4_r;
  assign out_sum_word = out_r;

`ifndef NO_ASSERTIONS
  // A stalled result must hold its word.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sum_word))
    else $error("result changed while stalled");
  // A valid transaction in the third stage reaches the output stage when the pipe advances.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v3_r |=> v4_r)
    else $error("valid bit lost in pipeline");
  // Input ready tracks the output stage.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted during output stall");
`endif

endmodule

`default_nettype wire

@@ verif/float32_adder_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_adder_top_tb: self-checking bench for the single-precision adder.
// Drives directed and random operand pairs, predicts every sum in the bench
// and compares it with the block's output, under random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

// Holds the sums the block still owes and checks each one as it arrives.
class sum_scoreboard;
  logic [31:0] pending_sums[$];
  int unsigned err_count;

  function new();
    err_count = 0;
  endfunction

  // Predicts the sum for one accepted transaction.
  function logic [31:0] predict_sum(logic [31:0] a, logic [31:0] b);
    logic [31:0] sa, sb, ma, mb, sign, big, sml, d, acc, f;
    logic [7:0] ea8, eb8;
    int ea, eb, ex;
    bit sticky, sub, no_round, up, both_den;
    fadd_pkg::kind_t ka, kb;
    sa = a >> 31;
    sb = b >> 31;
    ea8 = a[30:23];
    eb8 = b[30:23];
    ma = {9'd0, a[22:0]};
    mb = {9'd0, b[22:0]};
    ka = (ea8 == 0) ? (ma == 0 ? fadd_pkg::K_ZERO : fadd_pkg::K_DENORM) :
         (ea8 == 8'hFF) ? (ma == 0 ? fadd_pkg::K_INF : fadd_pkg::K_NAN) :
         fadd_pkg::K_NORMAL;
    kb = (eb8 == 0) ? (mb == 0 ? fadd_pkg::K_ZERO : fadd_pkg::K_DENORM) :
         (eb8 == 8'hFF) ? (mb == 0 ? fadd_pkg::K_INF : fadd_pkg::K_NAN) :
         fadd_pkg::K_NORMAL;
    // Special operands come first: NaN, then infinity, then zero.
    if (ka == fadd_pkg::K_NAN || kb == fadd_pkg::K_NAN)
      return (ka == fadd_pkg::K_NAN && kb != fadd_pkg::K_NAN) ?
             (a | fadd_pkg::QUIET_MASK) : (b | fadd_pkg::QUIET_MASK);
    if (ka == fadd_pkg::K_INF || kb == fadd_pkg::K_INF) begin
      if (ka != fadd_pkg::K_INF) return b;
      if (kb != fadd_pkg::K_INF) return a;
      return (sa == sb) ? a : fadd_pkg::INF_CLASH;
    end
    if (ka == fadd_pkg::K_ZERO || kb == fadd_pkg::K_ZERO) begin
      if (ka != fadd_pkg::K_ZERO) return a;
      if (kb != fadd_pkg::K_ZERO) return b;
      return (sa & sb) << 31;
    end
    ea = ea8;
    eb = eb8;
    if (ka == fadd_pkg::K_DENORM) ea = 1; else ma |= 32'h0080_0000;
    if (kb == fadd_pkg::K_DENORM) eb = 1; else mb |= 32'h0080_0000;
    both_den = (ka == fadd_pkg::K_DENORM) && (kb == fadd_pkg::K_DENORM);
    sticky = 0;
    no_round = 0;
    sub = (sa != sb);
    // Order the operands by magnitude.
    if (ea > eb) begin
      sign = sa; d = ea - eb; big = ma; sml = mb; ex = ea;
    end else if (ea < eb) begin
      sign = sb; d = eb - ea; big = mb; sml = ma; ex = eb;
    end else begin
      d = 0; ex = ea;
      if (ma < mb) begin
        sign = sb; big = mb; sml = ma;
      end else if (ma > mb) begin
        sign = sa; big = ma; sml = mb;
      end else if (!sub) begin
        sign = sa; big = ma; sml = mb;
      end else begin
        return 32'd0;
      end
    end
    big = (big << 2) & 32'h03FF_FFFC;
    sml = (sml << 2) & 32'h03FF_FFFC;
    // Align the smaller operand and collect the sticky bit.
    if (d >= 26) begin
      sticky = (sml != 0); sml = 0;
    end else if (d > 0) begin
      sticky = ((sml & ((32'd1 << d) - 1)) != 0); sml = sml >> d;
    end
    acc = sub ? big - sml : big + sml;
    if (acc == 0) return 32'd0;
    // Renormalize, with the block's own underflow handling.
    while (acc < 32'h0200_0000) begin
      if (both_den && ex <= 1) begin
        ex = 0; no_round = 1; break;
      end
      acc = acc << 1;
      ex--;
      if (ex < 0) begin
        ex = 0; acc = 0; no_round = 1; break;
      end
    end
    if (acc > 32'h03FF_FFFF) begin
      if (acc[0]) sticky = 1;
      acc = acc >> 1;
      ex++;
      if (ex >= 255) begin
        ex = 255; acc = 0; no_round = 1;
      end
    end
    // Round to nearest even; a subtraction with sticky set does not round up at the halfway point.
    f = acc & 3;
    acc = (acc >> 2) & 32'h00FF_FFFF;
    if (!no_round) begin
      if (f == 3) up = 1;
      else if (f == 2) up = sticky ? !sub : acc[0];
      else up = 0;
      if (up) acc++;
      if (acc > 32'h00FF_FFFF) begin
        acc = acc >> 1;
        ex++;
        if (ex >= 255) begin
          ex = 255; acc = 0;
        end
      end
    end
    return {sign[0], 8'(ex), acc[22:0]};
  endfunction

  function void note_operands(logic [31:0] a, logic [31:0] b);
    pending_sums.push_back(predict_sum(a, b));
  endfunction

  function void check_sum(logic [31:0] got);
    logic [31:0] want;
    if (pending_sums.size() == 0) begin
      $display("%0t: unexpected sum %h", $time, got);
      err_count++;
      return;
    end
    want = pending_sums.pop_front();
    if (got !== want) begin
      $display("%0t: sum_word mismatch expected %h actual %h", $time, want, got);
      err_count++;
    end
  endfunction
endclass

module float32_adder_top_tb;
  localparam int N_RANDOM = 1600;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] in_operand_a = '0;
  logic [31:0] in_operand_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_sum_word;

  sum_scoreboard sb = new();
  bit calm_tail = 0;
  bit send_done = 0;
  int unsigned cycle_cnt = 0;

  float32_adder_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_sum_word(out_sum_word)
  );

  always #5 clk = ~clk;

  // Sample both handshakes at the rising edge.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && in_valid && in_ready) sb.note_operands(in_operand_a, in_operand_b);
    if (rst_n && out_valid && out_ready) sb.check_sum(out_sum_word);
  end

  // Offers one transaction and holds it until accepted, sometimes with an idle burst first.
  task automatic send_pair(logic [31:0] a, logic [31:0] b);
    int gap;
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random single-precision word biased toward interesting classes.
  function automatic logic [31:0] pick_word(logic [7:0] near_exp);
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: w[30:23] = 8'h00;
      1: w[30:23] = 8'hFF;
      2: w[30:0] = 31'd0;
      3: w[30:23] = 8'hFE;
      4, 5, 6: w[30:23] = near_exp + 8'($urandom_range(0, 4)) - 8'd2;
      default: ;
    endcase
    return w;
  endfunction

  // Sender: directed corner cases, then random pairs.
  initial begin
    logic [31:0] a, b;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_pair(32'h7F80_0001, 32'h3F80_0000);
    send_pair(32'h3F80_0000, 32'hFF80_0001);
    send_pair(32'h7FC0_1234, 32'hFF80_5678);
    send_pair(32'h7F80_0000, 32'h4000_0000);
    send_pair(32'h4000_0000, 32'hFF80_0000);
    send_pair(32'hFF80_0000, 32'hFF80_0000);
    send_pair(32'h7F80_0000, 32'hFF80_0000);
    send_pair(32'h8000_0000, 32'h8000_0000);
    send_pair(32'h8000_0000, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'hC120_0000);
    send_pair(32'h3F80_0000, 32'hBF80_0000);
    send_pair(32'h0000_0001, 32'h0000_0002);
    send_pair(32'h007F_FFFF, 32'h0000_0001);
    send_pair(32'h8040_0000, 32'h0000_0001);
    send_pair(32'h0080_0000, 32'h807F_FFFF);
    send_pair(32'h0080_0001, 32'h8080_0000);
    send_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF);
    send_pair(32'h7F7F_FFFF, 32'h7380_0000);
    send_pair(32'h3F80_0000, 32'h3380_0001);
    send_pair(32'h3F80_0000, 32'hB300_0001);
    send_pair(32'h3F80_0001, 32'h3380_0000);
    send_pair(32'h4B80_0000, 32'hBF80_0001);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h3F80_0000, 32'h0000_0001);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 200) calm_tail = 1;
      a = pick_word(8'($urandom));
      b = ($urandom_range(0, 1)) ? pick_word(a[30:23]) : $urandom;
      if ($urandom_range(0, 7) == 0) b = {~a[31], a[30:0] ^ 31'($urandom_range(0, 3))};
      send_pair(a, b);
    end
    in_valid <= 1'b0;
    send_done = 1;
  end

  // Receiver: random stalls, one long hold-off to fill the pipeline.
  initial begin
    int gap;
    @(posedge rst_n);
    @(negedge clk);
    repeat (40) @(negedge clk);
    out_ready <= 1'b0;
    repeat (60) @(negedge clk);
    forever begin
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 6);
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
    end
  end

  // End of run and timeout.
  initial begin
    wait (send_done);
    while (sb.pending_sums.size() != 0 && cycle_cnt < CYCLE_LIMIT) @(negedge clk);
    repeat (10) @(negedge clk);
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
    end else if (sb.err_count == 0 && sb.pending_sums.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (cycle_cnt >= CYCLE_LIMIT + 100) begin
      $display("DONE: errors detected");
      $finish;
    end
  end
endmodule

`default_nettype wire

@@ filelist.f @@
rtl/fadd_pkg.sv
rtl/float32_adder_top.sv
verif/float32_adder_top_tb.sv
